/* sv/slc_pkg.sv */
`timescale 1ns / 1ps
// slc_pkg: types, character constants and helper functions for the literal classifier
// depends on nothing; imported by every module of the block
package slc_pkg;

	typedef enum logic [2:0] {
		CLS_NONE = 3'd0,
		CLS_HEX  = 3'd1,
		CLS_DEC  = 3'd2,
		CLS_REAL = 3'd3,
		CLS_STR  = 3'd4,
		CLS_NULL = 3'd5,
		CLS_BOOL = 3'd6
	} lit_class_t;

	typedef enum logic [1:0] {
		STR_OPEN   = 2'd0,
		STR_CLOSED = 2'd1,
		STR_AFTER  = 2'd2
	} str_state_t;

	typedef enum logic [1:0] {
		KW_NULL  = 2'd0,
		KW_TRUE  = 2'd1,
		KW_FALSE = 2'd2
	} kw_t;

	typedef struct packed {
		logic valid;
		logic point;
		logic digit;
		logic prevdot;
		logic exp_seen;
		logic expdig;
	} real_st_t;

	typedef struct packed {
		lit_class_t cls;
		logic       neg;
		logic       ovf;
		logic       bval;
	} tok_sum_t;

	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_LA    = "a";
	localparam logic [7:0] CH_LF    = "f";
	localparam logic [7:0] CH_UA    = "A";
	localparam logic [7:0] CH_UZ    = "Z";
	localparam logic [7:0] CH_X     = "x";
	localparam logic [7:0] CH_E     = "e";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_SQ    = "'";
	localparam logic [7:0] CH_DQ    = "\"";
	localparam logic [7:0] CH_BSL   = "\\";
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic [7:0] HEX_OFS  = 8'd10;

	localparam logic [2:0] POS_MAX  = 3'd7;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		is_sign = (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	function automatic logic is_hexd(input logic [7:0] c);
		logic [7:0] l;
		l = to_lower(c);
		is_hexd = is_dig(l) || (l >= CH_LA && l <= CH_LF);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] l;
		logic [7:0] v;
		l = to_lower(c);
		v = is_dig(l) ? l - CH_ZERO : l - CH_LA + HEX_OFS;
		hex_val = v[3:0];
	endfunction

	function automatic logic [2:0] kw_len(input kw_t kw);
		case (kw)
			KW_NULL:  kw_len = 3'd4;
			KW_TRUE:  kw_len = 3'd4;
			KW_FALSE: kw_len = 3'd5;
			default:  kw_len = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input kw_t kw, input logic [2:0] p);
		logic [39:0] w;
		case (kw)
			KW_NULL:  w = {"null", CH_NUL};
			KW_TRUE:  w = {"true", CH_NUL};
			KW_FALSE: w = "false";
			default:  w = '0;
		endcase
		case (p)
			3'd0:    kw_char = w[39:32];
			3'd1:    kw_char = w[31:24];
			3'd2:    kw_char = w[23:16];
			3'd3:    kw_char = w[15:8];
			3'd4:    kw_char = w[7:0];
			default: kw_char = CH_NUL;
		endcase
	endfunction

endpackage

/* sv/slc_if.sv */
`timescale 1ns / 1ps
// slc_char_if and slc_result_if: valid/ready channels of the literal classifier
// no dependencies
interface slc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_char;
	logic       last_char;

	modport source (output valid, token_char, last_char, input ready);
	modport sink (input valid, token_char, last_char, output ready);
endinterface

interface slc_result_if;
	logic              valid;
	logic              ready;
	logic [2:0]        literal_class;
	logic signed [31:0] int_value;
	logic              int_overflow;
	logic              bool_value;

	modport source (output valid, literal_class, int_value, int_overflow, bool_value,
		input ready);
	modport sink (input valid, literal_class, int_value, int_overflow, bool_value,
		output ready);
endinterface

/* sv/sql_literal_classifier.sv */
`timescale 1ns / 1ps
// sql_literal_classifier: classifies one literal token fed a character per word
// depends on slc_pkg, slc_if, slc_lexer, slc_format
//
// channel   dir  word
// tok_in    in   token_char[7:0], last_char
// lit_out   out  literal_class[2:0], int_value[31:0], int_overflow, bool_value
//
// one character per cycle sustained while no result waits unread behind a held last character;
// each character is held in the input register, then updates the recognizer state.
// a result is valid from the result register once its last character leaves the input register.
// reset clears all recognizer state and both valid flags; state also returns to start after
// every last character. input stalls only when a result waits unread and the held word is a
// last character.
module sql_literal_classifier import slc_pkg::*; #(
	parameter int INT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	slc_char_if.sink            tok_in,
	slc_result_if.source        lit_out
);

	logic                v_s1;
	logic [7:0]          ch_s1;
	logic                last_s1;
	logic                v_s2;
	tok_sum_t            sum_s2;
	logic [INT_BITS-1:0] mag_s2;

	logic                fire1;
	tok_sum_t            sum;
	logic [INT_BITS-1:0] mag;

	assign fire1        = v_s1 && (!last_s1 || !v_s2 || lit_out.ready);
	assign tok_in.ready = !v_s1 || fire1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (tok_in.ready)
				v_s1 <= tok_in.valid;
			if (fire1 && last_s1)
				v_s2 <= 1'b1;
			else if (lit_out.ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.ready && tok_in.valid) begin
			ch_s1   <= tok_in.token_char;
			last_s1 <= tok_in.last_char;
		end
		if (fire1 && last_s1) begin
			sum_s2 <= sum;
			mag_s2 <= mag;
		end
	end

	slc_lexer #(.INT_BITS(INT_BITS)) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire1),
		.ch     (ch_s1),
		.last   (last_s1),
		.sum    (sum),
		.mag    (mag)
	);

	slc_format #(.INT_BITS(INT_BITS)) u_format (
		.sum           (sum_s2),
		.mag           (mag_s2),
		.literal_class (lit_out.literal_class),
		.int_value     (lit_out.int_value),
		.int_overflow  (lit_out.int_overflow),
		.bool_value    (lit_out.bool_value)
	);

	assign lit_out.valid = v_s2;

endmodule

/* sv/slc_lexer.sv */
`timescale 1ns / 1ps
// slc_lexer: per-character recognizers and value accumulator of the literal classifier
// depends on slc_pkg
module slc_lexer import slc_pkg::*; #(
	parameter int INT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          ch,
	input  logic                last,
	output tok_sum_t            sum,
	output logic [INT_BITS-1:0] mag
);

	localparam int MW = INT_BITS + 5;
	localparam logic [MW-1:0] LIM = MW'(1) << (INT_BITS - 1);

	logic [2:0]          pos_q;
	logic [7:0]          first_q;
	logic                hex_q;
	logic                dec_q;
	real_st_t            real_q;
	logic [7:0]          quote_q;
	logic [7:0]          prev_q;
	str_state_t          closed_q;
	logic [2:0]          kw_q;
	logic [INT_BITS-1:0] mag_q;
	logic                ovf_q;
	logic                neg_q;

	logic [2:0]          pos_n;
	logic [7:0]          first_n;
	logic                hex_n;
	logic                dec_n;
	real_st_t            real_n;
	logic [7:0]          quote_n;
	str_state_t          closed_n;
	logic [2:0]          kw_n;
	logic [INT_BITS-1:0] mag_n;
	logic                ovf_n;
	logic                neg_n;

	logic [7:0]          lc;
	logic                sf;
	logic [2:0]          hex_start;
	logic [MW-1:0]       mag_w;
	logic [MW-1:0]       acc;
	logic                do_acc;
	logic                hex_ok;
	logic                dec_ok;
	logic                real_ok;
	logic                str_ok;

	always_comb begin
		lc      = to_lower(ch);
		first_n = (pos_q == 3'd0) ? ch : first_q;
		sf      = is_sign(first_n);

		// hex recognizer
		case (pos_q)
			3'd0:    hex_n = (ch == CH_ZERO) || sf;
			3'd1:    hex_n = hex_q && ((first_n == CH_ZERO) ? ch == CH_X : ch == CH_ZERO);
			3'd2:    hex_n = hex_q && (sf ? ch == CH_X : is_hexd(ch));
			default: hex_n = hex_q && is_hexd(ch);
		endcase

		// decimal recognizer
		if (pos_q == 3'd0) begin
			dec_n = is_dig(ch) || sf;
			neg_n = (ch == CH_MINUS);
		end else begin
			dec_n = dec_q && is_dig(ch);
			neg_n = neg_q;
		end

		// magnitude accumulator
		hex_start = sf ? 3'd2 : 3'd1;
		mag_w     = MW'(mag_q);
		acc       = '0;
		do_acc    = 1'b0;
		mag_n     = mag_q;
		ovf_n     = ovf_q;
		if (hex_n && pos_q == hex_start) begin
			mag_n = '0;
			ovf_n = 1'b0;
		end else if (hex_n && pos_q > hex_start) begin
			acc    = (mag_w << 4) + MW'(hex_val(ch));
			do_acc = 1'b1;
		end else if (dec_n && is_dig(ch)) begin
			acc    = (mag_w << 3) + (mag_w << 1) + MW'(ch[3:0]);
			do_acc = 1'b1;
		end
		if (do_acc) begin
			if (acc > LIM) begin
				mag_n = LIM[INT_BITS-1:0];
				ovf_n = 1'b1;
			end else begin
				mag_n = acc[INT_BITS-1:0];
			end
		end

		// real recognizer
		real_n = real_q;
		if (real_q.valid) begin
			if (real_q.exp_seen) begin
				if (is_dig(ch)) begin
					real_n.expdig = 1'b1;
				end else if (!(is_sign(ch) && !real_q.prevdot && !real_q.expdig
						&& prev_q == CH_E)) begin
					real_n.valid = 1'b0;
				end
				real_n.prevdot = 1'b0;
			end else if (pos_q == 3'd0 && is_sign(ch)) begin
				real_n = real_q;
			end else if (lc == CH_DOT) begin
				if (real_q.point)
					real_n.valid = 1'b0;
				real_n.point   = 1'b1;
				real_n.digit   = 1'b0;
				real_n.prevdot = 1'b1;
			end else if (lc == CH_E) begin
				if (!real_q.digit || real_q.prevdot)
					real_n.valid = 1'b0;
				real_n.exp_seen = 1'b1;
				real_n.prevdot  = 1'b0;
			end else if (is_dig(ch)) begin
				real_n.digit   = 1'b1;
				real_n.prevdot = 1'b0;
			end else begin
				real_n.valid = 1'b0;
			end
		end

		// quoted string
		quote_n  = quote_q;
		closed_n = closed_q;
		if (pos_q == 3'd0) begin
			quote_n  = (ch == CH_SQ || ch == CH_DQ) ? ch : CH_NUL;
			closed_n = STR_OPEN;
		end else if (closed_q != STR_OPEN) begin
			closed_n = STR_AFTER;
		end else if (quote_q != CH_NUL && ch == quote_q && prev_q != CH_BSL) begin
			closed_n = STR_CLOSED;
		end

		// keywords
		for (int k = 0; k < 3; k++) begin
			kw_n[k] = kw_q[k] && (pos_q < kw_len(kw_t'(k))) && (lc == kw_char(kw_t'(k), pos_q));
		end

		pos_n = (pos_q == POS_MAX) ? POS_MAX : pos_q + 3'd1;

		// token summary at the last character
		hex_ok  = hex_n && (pos_n >= (sf ? 3'd4 : 3'd3));
		dec_ok  = dec_n && !(pos_n == 3'd1 && sf);
		real_ok = real_n.valid && (real_n.exp_seen ? real_n.expdig : real_n.digit);
		str_ok  = (quote_n != CH_NUL) && (closed_n == STR_CLOSED);

		sum.neg  = neg_n;
		sum.ovf  = ovf_n;
		sum.bval = 1'b0;
		if (hex_ok) begin
			sum.cls = CLS_HEX;
		end else if (dec_ok) begin
			sum.cls = CLS_DEC;
		end else if (real_ok) begin
			sum.cls = CLS_REAL;
		end else if (str_ok) begin
			sum.cls = CLS_STR;
		end else if (kw_n[KW_NULL] && pos_n == 3'd4) begin
			sum.cls = CLS_NULL;
		end else if ((kw_n[KW_TRUE] && pos_n == 3'd4) || (kw_n[KW_FALSE] && pos_n == 3'd5)) begin
			sum.cls  = CLS_BOOL;
			sum.bval = kw_n[KW_TRUE] && (pos_n == 3'd4);
		end else begin
			sum.cls = CLS_NONE;
		end
		mag = mag_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			first_q  <= CH_NUL;
			hex_q    <= 1'b1;
			dec_q    <= 1'b1;
			real_q   <= '{valid: 1'b1, default: 1'b0};
			quote_q  <= CH_NUL;
			prev_q   <= CH_NUL;
			closed_q <= STR_OPEN;
			kw_q     <= '1;
			mag_q    <= '0;
			ovf_q    <= 1'b0;
			neg_q    <= 1'b0;
		end else if (en) begin
			if (last) begin
				pos_q    <= '0;
				first_q  <= CH_NUL;
				hex_q    <= 1'b1;
				dec_q    <= 1'b1;
				real_q   <= '{valid: 1'b1, default: 1'b0};
				quote_q  <= CH_NUL;
				prev_q   <= CH_NUL;
				closed_q <= STR_OPEN;
				kw_q     <= '1;
				mag_q    <= '0;
				ovf_q    <= 1'b0;
				neg_q    <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				first_q  <= first_n;
				hex_q    <= hex_n;
				dec_q    <= dec_n;
				real_q   <= real_n;
				quote_q  <= quote_n;
				prev_q   <= lc;
				closed_q <= closed_n;
				kw_q     <= kw_n;
				mag_q    <= mag_n;
				ovf_q    <= ovf_n;
				neg_q    <= neg_n;
			end
		end
	end

endmodule

/* sv/slc_format.sv */
`timescale 1ns / 1ps
// slc_format: turns a registered token summary into the result fields
// depends on slc_pkg
module slc_format import slc_pkg::*; #(
	parameter int INT_BITS = 32
) (
	input  tok_sum_t            sum,
	input  logic [INT_BITS-1:0] mag,
	output logic [2:0]          literal_class,
	output logic signed [31:0]  int_value,
	output logic                int_overflow,
	output logic                bool_value
);

	localparam int OW = (INT_BITS > 32) ? INT_BITS : 32;
	localparam logic [INT_BITS-1:0] POS_MAX_VAL = {1'b0, {(INT_BITS-1){1'b1}}};

	logic [OW-1:0] val;
	logic          ovf;

	always_comb begin
		val = '0;
		ovf = 1'b0;
		if (sum.cls == CLS_HEX || sum.cls == CLS_DEC) begin
			if (sum.neg) begin
				val = '0 - OW'(mag);
				ovf = sum.ovf;
			end else if (mag[INT_BITS-1]) begin
				val = OW'(POS_MAX_VAL);
				ovf = 1'b1;
			end else begin
				val = OW'(mag);
				ovf = sum.ovf;
			end
		end
		literal_class = sum.cls;
		int_value     = val[31:0];
		int_overflow  = ovf;
		bool_value    = (sum.cls == CLS_BOOL) && sum.bval;
	end

endmodule

/* sim/slc_lit_checker.sv */
`timescale 1ns / 1ps
// slc_lit_checker: watches both channels of sql_literal_classifier, predicts each result word
// from the accepted character words and compares it field by field; depends on slc_pkg
module slc_lit_checker import slc_pkg::*; #(
	parameter int INT_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	input  logic               tok_ready,
	input  logic [7:0]         token_char,
	input  logic               last_char,
	input  logic               lit_valid,
	input  logic               lit_ready,
	input  logic [2:0]         literal_class,
	input  logic signed [31:0] int_value,
	input  logic               int_overflow,
	input  logic               bool_value,
	output int unsigned        pending,
	output int unsigned        fail_count
);

	typedef struct packed {
		lit_class_t  cls;
		logic [31:0] value;
		logic        ovf;
		logic        bval;
	} lit_word_t;

	localparam logic [63:0] MAG_LIM = 64'd1 << (INT_BITS - 1);

	logic [2:0]  pos;
	logic [7:0]  first_ch;
	logic [7:0]  quote_ch;
	logic [7:0]  prev_ch;
	logic        hex_live;
	logic        dec_live;
	logic        neg;
	real_st_t    rs;
	str_state_t  str_st;
	logic [2:0]  kw_live;
	logic [63:0] mag;
	logic        mag_ovf;
	lit_word_t   lit_q[$];
	lit_word_t   want;
	int unsigned err_n;

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c | 8'h20 : c;
	endfunction

	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic sgn(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS;
	endfunction

	function automatic logic hexdig(input logic [7:0] c);
		return digit(c) || (fold(c) >= "a" && fold(c) <= "f");
	endfunction

	function automatic logic [3:0] nib(input logic [7:0] c);
		return digit(c) ? 4'(c - "0") : 4'(fold(c) - "a" + 8'd10);
	endfunction

	function automatic logic kw_hit(input kw_t k, input logic [2:0] p, input logic [7:0] c);
		logic [39:0] word;
		int unsigned n;
		case (k)
			KW_NULL: begin
				word = {"null", 8'h00};
				n = 4;
			end
			KW_TRUE: begin
				word = {"true", 8'h00};
				n = 4;
			end
			default: begin
				word = "false";
				n = 5;
			end
		endcase
		return (p < n) ? fold(c) == word[39 - 8 * p -: 8] : 1'b0;
	endfunction

	task automatic clear_state();
		pos      = '0;
		first_ch = '0;
		quote_ch = '0;
		prev_ch  = '0;
		hex_live = 1'b1;
		dec_live = 1'b1;
		neg      = 1'b0;
		rs       = '0;
		rs.valid = 1'b1;
		str_st   = STR_OPEN;
		kw_live  = 3'b111;
		mag      = '0;
		mag_ovf  = 1'b0;
	endtask

	task automatic add_digit(input logic [4:0] base, input logic [3:0] d);
		if (mag > (MAG_LIM - 64'(d)) / 64'(base)) begin
			mag = MAG_LIM;
			mag_ovf = 1'b1;
		end else begin
			mag = mag * 64'(base) + 64'(d);
		end
	endtask

	task automatic take_char(input logic [7:0] c, input logic last);
		logic [7:0]  lead;
		logic [7:0]  lc;
		logic        slead;
		logic [2:0]  len;
		logic        hex_ok;
		logic        dec_ok;
		logic        real_ok;
		logic        str_ok;
		logic [63:0] m;
		lit_word_t   w;
		lead  = (pos == 0) ? c : first_ch;
		slead = sgn(lead);
		lc    = fold(c);

		if (pos == 0)
			hex_live = (c == CH_ZERO) || slead;
		else if (pos == 1)
			hex_live = hex_live && ((lead == CH_ZERO) ? c == CH_X : c == CH_ZERO);
		else if (pos == 2)
			hex_live = hex_live && (slead ? c == CH_X : hexdig(c));
		else
			hex_live = hex_live && hexdig(c);

		if (pos == 0) begin
			dec_live = digit(c) || slead;
			neg = (c == CH_MINUS);
		end else begin
			dec_live = dec_live && digit(c);
		end

		if (hex_live && pos == (slead ? 3'd2 : 3'd1)) begin
			mag = '0;
			mag_ovf = 1'b0;
		end else if (hex_live && pos >= (slead ? 3'd3 : 3'd2)) begin
			add_digit(5'd16, nib(c));
		end else if (dec_live && digit(c)) begin
			add_digit(5'd10, nib(c));
		end

		if (rs.valid) begin
			if (rs.exp_seen) begin
				if (digit(c))
					rs.expdig = 1'b1;
				else if (!(sgn(c) && !rs.prevdot && !rs.expdig && prev_ch == CH_E))
					rs.valid = 1'b0;
				rs.prevdot = 1'b0;
			end else if (pos == 0 && sgn(c)) begin
			end else if (lc == CH_DOT) begin
				if (rs.point)
					rs.valid = 1'b0;
				rs.point = 1'b1;
				rs.digit = 1'b0;
				rs.prevdot = 1'b1;
			end else if (lc == CH_E) begin
				if (!rs.digit || rs.prevdot)
					rs.valid = 1'b0;
				rs.exp_seen = 1'b1;
				rs.prevdot = 1'b0;
			end else if (digit(c)) begin
				rs.digit = 1'b1;
				rs.prevdot = 1'b0;
			end else begin
				rs.valid = 1'b0;
			end
		end

		if (pos == 0) begin
			quote_ch = (c == CH_SQ || c == CH_DQ) ? c : 8'h00;
			str_st = STR_OPEN;
		end else if (str_st != STR_OPEN) begin
			str_st = STR_AFTER;
		end else if (quote_ch != 0 && c == quote_ch && prev_ch != CH_BSL) begin
			str_st = STR_CLOSED;
		end

		if (!kw_hit(KW_NULL, pos, c))
			kw_live[KW_NULL] = 1'b0;
		if (!kw_hit(KW_TRUE, pos, c))
			kw_live[KW_TRUE] = 1'b0;
		if (!kw_hit(KW_FALSE, pos, c))
			kw_live[KW_FALSE] = 1'b0;

		if (pos == 0)
			first_ch = c;
		prev_ch = lc;
		if (pos != POS_MAX)
			pos = pos + 3'd1;
		len = pos;

		if (last) begin
			hex_ok  = hex_live && len >= (slead ? 3'd4 : 3'd3);
			dec_ok  = dec_live && !(len == 1 && slead);
			real_ok = rs.valid && (rs.exp_seen ? rs.expdig : rs.digit);
			str_ok  = quote_ch != 0 && str_st == STR_CLOSED;
			w.cls   = CLS_NONE;
			w.value = '0;
			w.ovf   = 1'b0;
			w.bval  = 1'b0;
			if (hex_ok || dec_ok) begin
				if (hex_ok)
					w.cls = CLS_HEX;
				else
					w.cls = CLS_DEC;
				m = mag;
				w.ovf = mag_ovf;
				if (neg) begin
					m = 64'd0 - m;
				end else if (m > MAG_LIM - 64'd1) begin
					m = MAG_LIM - 64'd1;
					w.ovf = 1'b1;
				end
				w.value = m[31:0];
			end else if (real_ok) begin
				w.cls = CLS_REAL;
			end else if (str_ok) begin
				w.cls = CLS_STR;
			end else if (kw_live[KW_NULL] && len == 4) begin
				w.cls = CLS_NULL;
			end else if ((kw_live[KW_TRUE] && len == 4) || (kw_live[KW_FALSE] && len == 5)) begin
				w.cls = CLS_BOOL;
				w.bval = kw_live[KW_TRUE] && len == 4;
			end
			lit_q.push_back(w);
			clear_state();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			lit_q.delete();
			err_n = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (lit_valid && lit_ready) begin
				if (lit_q.size() == 0) begin
					$error("result word with no token pending: class %0d value %0d",
						literal_class, int_value);
					err_n++;
				end else begin
					want = lit_q.pop_front();
					if (literal_class !== want.cls) begin
						$error("literal_class: expected %0d, got %0d", want.cls, literal_class);
						err_n++;
					end
					if (int_value !== want.value) begin
						$error("int_value: expected %0d, got %0d", $signed(want.value), int_value);
						err_n++;
					end
					if (int_overflow !== want.ovf) begin
						$error("int_overflow: expected %0d, got %0d", want.ovf, int_overflow);
						err_n++;
					end
					if (bool_value !== want.bval) begin
						$error("bool_value: expected %0d, got %0d", want.bval, bool_value);
						err_n++;
					end
				end
			end
			if (tok_valid && tok_ready)
				take_char(token_char, last_char);
			pending <= lit_q.size();
			fail_count <= err_n;
		end
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// tb: drives sql_literal_classifier with directed literal tokens, then random well-formed, noise and
// damaged tokens under random idling; depends on slc_pkg, slc_if, the block and slc_lit_checker
module tb;
	import slc_pkg::*;

	typedef enum int {
		TK_HEX,
		TK_DEC,
		TK_REAL,
		TK_QUOTED,
		TK_WORD,
		TK_NOISE
	} tok_kind_t;

	localparam int unsigned ITEM_TARGET  = 1000;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned CHOKE_CYCLES = 400;
	localparam int unsigned CHOKE_TOK    = 40;
	localparam int unsigned PAUSE_TOK    = 90;

	logic        clk;
	logic        arst_n;
	logic        choke_req;
	logic        no_gaps;
	int unsigned pending;
	int unsigned fail_count;
	int unsigned sent;
	logic [7:0]  tok_buf[$];

	string directed_toks[24] = '{
		"0", "0x7FFFFFFF", "-0x80000000", "0xfFfFfFfFf", "+0x1a", "2147483647",
		"2147483648", "-2147483648", "-99999999999", "+", "+0", "-1.5", ".25E+3", "1.",
		"1e-", "12345678.9", "'it\\'s'", "\"ab\"c", "'", "null", "TRUE", "False",
		"falsee", "0X1F"
	};

	slc_char_if   tok_if();
	slc_result_if lit_if();

	sql_literal_classifier dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (tok_if),
		.lit_out (lit_if)
	);

	slc_lit_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (tok_if.valid),
		.tok_ready     (tok_if.ready),
		.token_char    (tok_if.token_char),
		.last_char     (tok_if.last_char),
		.lit_valid     (lit_if.valid),
		.lit_ready     (lit_if.ready),
		.literal_class (lit_if.literal_class),
		.int_value     (lit_if.int_value),
		.int_overflow  (lit_if.int_overflow),
		.bool_value    (lit_if.bool_value),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] odd_char();
		case ($urandom_range(0, 11))
			0:       return 8'("0" + $urandom_range(0, 9));
			1:       return CH_PLUS;
			2:       return CH_MINUS;
			3:       return CH_DOT;
			4:       return $urandom_range(0, 1) ? "e" : "E";
			5:       return $urandom_range(0, 1) ? "x" : "X";
			6:       return CH_SQ;
			7:       return CH_DQ;
			8:       return CH_BSL;
			9:       return 8'("a" + $urandom_range(0, 25));
			10:      return 8'("A" + $urandom_range(0, 25));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			tok_buf.push_back(s[i]);
	endtask

	task automatic put_digits(input int unsigned n);
		repeat (n)
			tok_buf.push_back(8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic put_sign();
		if ($urandom_range(0, 2) == 0)
			tok_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
	endtask

	task automatic build_token(input tok_kind_t kind);
		logic [7:0]  q;
		logic [7:0]  c;
		string       kw;
		int unsigned n;
		case (kind)
			TK_HEX: begin
				put_sign();
				put_text("0x");
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
				repeat (n) begin
					c = 8'($urandom_range(0, 15));
					if (c < 10)
						tok_buf.push_back(8'("0" + c));
					else
						tok_buf.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + c - 10));
				end
			end
			TK_DEC: begin
				put_sign();
				put_digits(($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) :
					$urandom_range(1, 9));
			end
			TK_REAL: begin
				put_sign();
				put_digits($urandom_range(0, 4));
				if ($urandom_range(0, 3) != 0) begin
					tok_buf.push_back(CH_DOT);
					put_digits($urandom_range(0, 4));
				end
				if ($urandom_range(0, 1)) begin
					tok_buf.push_back($urandom_range(0, 1) ? "e" : "E");
					put_sign();
					put_digits($urandom_range(0, 3));
				end
			end
			TK_QUOTED: begin
				q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
				tok_buf.push_back(q);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 5))
						0: tok_buf.push_back(CH_BSL);
						1: begin
							tok_buf.push_back(CH_BSL);
							tok_buf.push_back(q);
						end
						2: tok_buf.push_back(q == CH_SQ ? CH_DQ : CH_SQ);
						default: tok_buf.push_back(odd_char());
					endcase
				end
				if ($urandom_range(0, 9) != 0)
					tok_buf.push_back(q);
				if ($urandom_range(0, 6) == 0)
					tok_buf.push_back(odd_char());
			end
			TK_WORD: begin
				case ($urandom_range(0, 2))
					0:       kw = "null";
					1:       kw = "true";
					default: kw = "false";
				endcase
				for (int i = 0; i < kw.len(); i++) begin
					c = kw[i];
					tok_buf.push_back($urandom_range(0, 1) ? c - 8'd32 : c);
				end
			end
			default: begin
				repeat ($urandom_range(1, 10))
					tok_buf.push_back(odd_char());
			end
		endcase
	endtask

	task automatic send_token();
		int unsigned gap;
		for (int i = 0; i < tok_buf.size(); i++) begin
			gap = no_gaps ? 0 : gap_len();
			if (gap != 0) begin
				tok_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tok_if.valid      <= 1'b1;
			tok_if.token_char <= tok_buf[i];
			tok_if.last_char  <= (i == tok_buf.size() - 1);
			do @(posedge clk); while (!tok_if.ready);
			sent++;
		end
		tok_buf.delete();
	endtask

	task automatic drain();
		tok_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// result side: short and long stalls, calm stretches, one long choke
	initial begin
		int unsigned hold;
		int unsigned calm;
		int unsigned r;
		logic        choke_done;
		lit_if.ready = 1'b0;
		hold = 0;
		calm = 0;
		choke_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (choke_req && !choke_done) begin
				choke_done = 1'b1;
				hold = CHOKE_CYCLES;
			end
			if (hold != 0) begin
				hold--;
				lit_if.ready <= 1'b0;
			end else if (calm != 0) begin
				calm--;
				lit_if.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					calm = $urandom_range(30, 150);
				else if (r < 25)
					hold = $urandom_range(1, 3);
				else if (r < 29)
					hold = $urandom_range(10, 50);
				lit_if.ready <= (hold == 0);
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned n_tok;
		int unsigned r;
		int unsigned at;
		tok_kind_t   kind;
		tok_if.valid      = 1'b0;
		tok_if.token_char = 8'h00;
		tok_if.last_char  = 1'b0;
		arst_n            = 1'b0;
		choke_req         = 1'b0;
		no_gaps           = 1'b0;
		sent              = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_toks[i]) begin
			put_text(directed_toks[i]);
			send_token();
		end
		tok_buf.push_back(8'hFF);
		send_token();
		tok_buf.push_back(8'h80);
		tok_buf.push_back(8'h00);
		send_token();
		drain();

		n_tok = 0;
		while (sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 17)
				kind = TK_HEX;
			else if (r < 34)
				kind = TK_DEC;
			else if (r < 52)
				kind = TK_REAL;
			else if (r < 68)
				kind = TK_QUOTED;
			else if (r < 84)
				kind = TK_WORD;
			else
				kind = TK_NOISE;
			build_token(kind);
			// damaged variant of a well-formed token
			if (kind != TK_NOISE && tok_buf.size() != 0 && $urandom_range(0, 6) == 0) begin
				at = $urandom_range(0, tok_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: tok_buf[at] = odd_char();
					1: if (tok_buf.size() > 1) tok_buf.delete(at);
					default: tok_buf.insert(at, odd_char());
				endcase
			end
			if (n_tok == CHOKE_TOK)
				choke_req <= 1'b1;
			no_gaps = (n_tok >= CHOKE_TOK && n_tok < CHOKE_TOK + 12) ||
				($urandom_range(0, 4) == 0);
			send_token();
			if (n_tok == PAUSE_TOK)
				drain();
			n_tok++;
		end
		drain();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
